// ===== rtl/tcbd_pkg.sv =====
package tcbd_pkg;

    typedef enum logic [4:0] {
        TGT_NONE        = 5'd0,
        TGT_SPRITE_REGS = 5'd1,
        TGT_SPRITE_RAM  = 5'd2,
        TGT_PALETTE     = 5'd3,
        TGT_SHARED_RAM  = 5'd4,
        TGT_MAIN_MEM    = 5'd5,
        TGT_MAIN_ROM    = 5'd6,
        TGT_ZOOM_RAM    = 5'd7,
        TGT_ZOOM_ROM    = 5'd8,
        TGT_ZOOM_CTRL   = 5'd9,
        TGT_TILE_CHIP   = 5'd10,
        TGT_SUB_ROM     = 5'd11,
        TGT_SUB_MEM     = 5'd12,
        TGT_SOUND_MEM   = 5'd13,
        TGT_PCM0        = 5'd14,
        TGT_PCM1        = 5'd15,
        TGT_FM_STATUS   = 5'd16,
        TGT_FM_SELECT   = 5'd17,
        TGT_FM_DATA     = 5'd18,
        TGT_PCM_BANK    = 5'd19,
        TGT_PCM1_VOL    = 5'd20
    } t_target;

    typedef enum logic [1:0] {
        PORT_MAIN  = 2'd0,
        PORT_SUB   = 2'd1,
        PORT_SOUND = 2'd2,
        PORT_NONE  = 2'd3
    } t_bus_port;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // main CPU register groups, address bits 8..6
    typedef enum logic [2:0] {
        GRP_GUN    = 3'd0,
        GRP_SIRQ   = 3'd1,
        GRP_LATCH  = 3'd2,
        GRP_BANK   = 3'd3,
        GRP_P2     = 3'd4,
        GRP_SPARE  = 3'd5,
        GRP_INPUTS = 3'd6,
        GRP_DIP_C  = 3'd7
    } t_group;

    // low two address bits inside the input group
    localparam logic [1:0] SEL_SYSTEM = 2'd0;
    localparam logic [1:0] SEL_P1     = 2'd1;
    localparam logic [1:0] SEL_DIP_A  = 2'd2;
    localparam logic [1:0] SEL_DIP_B  = 2'd3;

    localparam logic [1:0] CFG_DIP_A = 2'd0;
    localparam logic [1:0] CFG_DIP_B = 2'd1;
    localparam logic [1:0] CFG_DIP_C = 2'd2;

    localparam logic [7:0] GUN_SEED   = 8'h5a;
    localparam logic [3:0] SUB_BANKS  = 4'd9;
    localparam logic [7:0] DIP_RESET  = 8'hff;

    typedef struct packed {
        logic [1:0]  bus_port;
        logic        operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  player_one_port;
        logic [7:0]  player_two_port;
        logic [7:0]  system_port;
    } t_access;

    typedef struct packed {
        logic [3:0] main_rom_bank;
        logic [3:0] sub_rom_bank;
        logic [7:0] sound_latch_byte;
        logic       sub_firq_enabled;
        logic [7:0] gun_counter;
        logic       priority_flag;
        logic       rom_read_flag;
        logic       wraparound_flag;
    } t_glue;

    typedef struct packed {
        t_target     target;
        logic [16:0] device_offset;
        logic [7:0]  read_data;
        logic [7:0]  device_write_data;
        logic        sub_fast_irq;
        logic        sound_irq;
        logic        watchdog_kick;
        logic        layer_priority;
        logic        tile_rom_read_mode;
        logic        zoom_wraparound;
    } t_result;

endpackage

// ===== rtl/tcbd_acc_if.sv =====
interface tcbd_acc_if;
    logic        valid;
    logic        ready;
    logic [1:0]  bus_port;
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  player_one_port;
    logic [7:0]  player_two_port;
    logic [7:0]  system_port;

    modport source (
        output valid, bus_port, operation, address, write_data,
               player_one_port, player_two_port, system_port,
        input  ready
    );
    modport sink (
        input  valid, bus_port, operation, address, write_data,
               player_one_port, player_two_port, system_port,
        output ready
    );
endinterface

// ===== rtl/tcbd_res_if.sv =====
interface tcbd_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  target;
    logic [16:0] device_offset;
    logic [7:0]  read_data;
    logic [7:0]  device_write_data;
    logic        sub_fast_irq;
    logic        sound_irq;
    logic        watchdog_kick;
    logic        layer_priority;
    logic        tile_rom_read_mode;
    logic        zoom_wraparound;

    modport source (
        output valid, target, device_offset, read_data, device_write_data,
               sub_fast_irq, sound_irq, watchdog_kick, layer_priority,
               tile_rom_read_mode, zoom_wraparound,
        input  ready
    );
    modport sink (
        input  valid, target, device_offset, read_data, device_write_data,
               sub_fast_irq, sound_irq, watchdog_kick, layer_priority,
               tile_rom_read_mode, zoom_wraparound,
        output ready
    );
endinterface

// ===== rtl/tcbd_in_reg.sv =====
module tcbd_in_reg
    import tcbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    tcbd_acc_if.sink    i_acc,
    output logic        o_valid,
    output t_access     o_acc
);

    logic    r_valid;
    t_access r_acc;

    assign i_acc.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_acc.ready) begin
            r_valid <= i_acc.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc.valid && i_acc.ready) begin
            r_acc.bus_port        <= i_acc.bus_port;
            r_acc.operation       <= i_acc.operation;
            r_acc.address         <= i_acc.address;
            r_acc.write_data      <= i_acc.write_data;
            r_acc.player_one_port <= i_acc.player_one_port;
            r_acc.player_two_port <= i_acc.player_two_port;
            r_acc.system_port     <= i_acc.system_port;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;

endmodule

// ===== rtl/tcbd_decode.sv =====
module tcbd_decode
    import tcbd_pkg::*;
(
    input  t_access    i_acc,
    input  t_glue      i_glue,
    input  logic [7:0] i_dip_a,
    input  logic [7:0] i_dip_b,
    input  logic [7:0] i_dip_c,
    output t_result    o_res,
    output t_glue      o_glue
);

    logic        wr;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  gun_val;
    logic [3:0]  sub_bank_mod;
    logic        vol_wr;
    t_group      grp;
    t_result     res;
    t_glue       glue;

    assign wr = (i_acc.operation == OP_WRITE);
    assign a  = i_acc.address;
    assign d  = i_acc.write_data;
    assign grp = t_group'(a[8:6]);

    // counter * 17 + seed, all mod 256
    assign gun_val = i_glue.gun_counter + {i_glue.gun_counter[3:0], 4'h0} + GUN_SEED;

    assign sub_bank_mod = (i_glue.sub_rom_bank >= SUB_BANKS)
                        ? i_glue.sub_rom_bank - SUB_BANKS : i_glue.sub_rom_bank;

    always_comb begin
        res    = '0;
        res.target = TGT_NONE;
        glue   = i_glue;
        vol_wr = 1'b0;

        unique case (t_bus_port'(i_acc.bus_port))
            PORT_MAIN: begin
                if (a <= 16'h01c0) begin
                    if (!wr) begin
                        unique case (grp)
                            GRP_GUN: begin
                                res.read_data    = gun_val;
                                glue.gun_counter = i_glue.gun_counter + 8'd1;
                            end
                            GRP_P2:  res.read_data = i_acc.player_two_port;
                            GRP_INPUTS: begin
                                unique case (a[1:0])
                                    SEL_SYSTEM: res.read_data = i_acc.system_port;
                                    SEL_P1:     res.read_data = i_acc.player_one_port;
                                    SEL_DIP_A:  res.read_data = i_dip_a;
                                    SEL_DIP_B:  res.read_data = i_dip_b;
                                    default:    res.read_data = i_dip_b;
                                endcase
                            end
                            GRP_DIP_C: res.read_data = i_dip_c;
                            default:   res.read_data = 8'hff;
                        endcase
                    end else begin
                        unique case (grp)
                            GRP_GUN: begin
                                if (a == 16'h0000) begin
                                    res.sub_fast_irq = i_glue.sub_firq_enabled;
                                end else begin
                                    res.watchdog_kick = 1'b1;
                                end
                            end
                            GRP_SIRQ:  res.sound_irq = 1'b1;
                            GRP_LATCH: glue.sound_latch_byte = d;
                            GRP_BANK: begin
                                glue.main_rom_bank = {1'b0, ~d[7], 2'b00} + {1'b0, d[2:0]};
                                glue.priority_flag = d[3];
                            end
                            default: ;
                        endcase
                    end
                end else if (a >= 16'h0800 && a <= 16'h0807) begin
                    res.target        = TGT_SPRITE_REGS;
                    res.device_offset = {14'd0, a[2:0]};
                end else if (a >= 16'h0c00 && a <= 16'h0fff) begin
                    res.target        = TGT_SPRITE_RAM;
                    res.device_offset = {7'd0, a[9:0]};
                end else if (a >= 16'h1000 && a <= 16'h1fff) begin
                    res.target        = TGT_PALETTE;
                    res.device_offset = {5'd0, a[11:0]};
                end else if (a >= 16'h2000 && a <= 16'h3fff) begin
                    res.target        = TGT_SHARED_RAM;
                    res.device_offset = {4'd0, a[12:0]};
                end else if (a >= 16'h4000 && a <= 16'h5fff) begin
                    res.target        = TGT_MAIN_MEM;
                    res.device_offset = {1'b0, a};
                end else if (wr) begin
                    // drop writes to ROM and unmapped space
                end else if (a >= 16'h6000 && a <= 16'h7fff) begin
                    res.target        = TGT_MAIN_ROM;
                    res.device_offset = {i_glue.main_rom_bank, a[12:0]};
                end else begin
                    res.target        = TGT_MAIN_MEM;
                    res.device_offset = {1'b0, a};
                end
            end

            PORT_SUB: begin
                if (a <= 16'h07ff) begin
                    res.target        = TGT_ZOOM_RAM;
                    res.device_offset = {1'b0, a};
                end else if (a >= 16'h2000 && a <= 16'h3fff) begin
                    res.target        = TGT_SHARED_RAM;
                    res.device_offset = {4'd0, a[12:0]};
                end else if (a >= 16'h4000 && a <= 16'h7fff) begin
                    res.target        = TGT_TILE_CHIP;
                    res.device_offset = {3'd0, a[13:0]};
                end else if (wr) begin
                    if (a >= 16'h0800 && a <= 16'h080f) begin
                        res.target        = TGT_ZOOM_CTRL;
                        res.device_offset = {13'd0, a[3:0]};
                    end else if (a == 16'h1800) begin
                        glue.rom_read_flag    = d[6];
                        glue.wraparound_flag  = d[5];
                        glue.sub_firq_enabled = d[4];
                        glue.sub_rom_bank     = d[3:0];
                    end
                end else if (a >= 16'h1000 && a <= 16'h17ff) begin
                    res.target        = TGT_ZOOM_ROM;
                    res.device_offset = {6'd0, a[10:0]};
                end else if (a >= 16'h8000 && a <= 16'h9fff) begin
                    res.target        = TGT_SUB_ROM;
                    res.device_offset = {sub_bank_mod, a[12:0]};
                end else begin
                    res.target        = TGT_SUB_MEM;
                    res.device_offset = {1'b0, a};
                end
            end

            PORT_SOUND: begin
                if (a >= 16'ha000 && a <= 16'ha00d) begin
                    res.target        = TGT_PCM0;
                    res.device_offset = {13'd0, a[3:0]};
                end else if (a >= 16'hb000 && a <= 16'hb00d) begin
                    res.target        = TGT_PCM1;
                    res.device_offset = {13'd0, a[3:0]};
                end else if (!wr) begin
                    if (a <= 16'h87ff) begin
                        res.target        = TGT_SOUND_MEM;
                        res.device_offset = {1'b0, a};
                    end else if (a == 16'hc001) begin
                        res.target = TGT_FM_STATUS;
                    end else if (a == 16'he000) begin
                        res.read_data = i_glue.sound_latch_byte;
                    end
                end else if (a >= 16'h8000 && a <= 16'h87ff) begin
                    res.target        = TGT_SOUND_MEM;
                    res.device_offset = {1'b0, a};
                end else if (a == 16'h9000) begin
                    res.target = TGT_PCM_BANK;
                end else if (a == 16'hb80c) begin
                    res.target = TGT_PCM1_VOL;
                    vol_wr     = 1'b1;
                end else if (a == 16'hc000) begin
                    res.target = TGT_FM_SELECT;
                end else if (a == 16'hc001) begin
                    res.target = TGT_FM_DATA;
                end
            end

            default: ;
        endcase

        if (!wr || res.target == TGT_NONE) begin
            res.device_write_data = 8'h00;
        end else if (vol_wr) begin
            res.device_write_data = {1'b0, d[3:0], 3'b000};
        end else begin
            res.device_write_data = d;
        end
        if (wr || res.target != TGT_NONE) begin
            res.read_data = 8'h00;
        end

        res.layer_priority     = glue.priority_flag;
        res.tile_rom_read_mode = glue.rom_read_flag;
        res.zoom_wraparound    = glue.wraparound_flag;
    end

    assign o_res  = res;
    assign o_glue = glue;

endmodule

// ===== rtl/three_cpu_bus_decoder.sv =====
// Bus decoder and glue registers for a three-CPU board (main, sub, sound).
//
// i_acc carries one bus transaction: issuing CPU, read/write, address, write
// byte and the live joystick and system ports. o_res returns one result per
// transaction: target device code, offset inside the device (banked ROM
// offsets composed here), local read data, the byte passed to the device,
// interrupt and watchdog pulses, and the priority, tile ROM-read and zoom
// wraparound levels after the transaction.
// The DIP switch bytes are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must do so only while no transaction is in flight; the block does not enforce this.
//
// o_res.valid rises once an accepted transaction has passed one input register,
// one decode pass and one result register. Throughput is one transaction per
// cycle while the receiver does not stall; the bank, latch and flag registers
// update in the same decode pass.
// Reset clears all glue registers to zero, the DIP bytes to 0xff and both
// stages to empty. When the receiver stalls, the result register holds and
// the input register takes one more transaction only if it is empty; once it
// holds one, i_acc.ready drops.
module three_cpu_bus_decoder
    import tcbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    tcbd_acc_if.sink    i_acc,
    tcbd_res_if.source  o_res
);

    logic       adv;
    logic       in_valid;
    t_access    in_acc;
    t_result    dec_res;
    t_glue      n_glue;
    t_glue      r_glue;
    t_result    r_res;
    logic       r_res_valid;
    logic [7:0] r_dip_a;
    logic [7:0] r_dip_b;
    logic [7:0] r_dip_c;

    assign adv = !r_res_valid || o_res.ready;

    tcbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_acc   (i_acc),
        .o_valid (in_valid),
        .o_acc   (in_acc)
    );

    tcbd_decode u_decode (
        .i_acc   (in_acc),
        .i_glue  (r_glue),
        .i_dip_a (r_dip_a),
        .i_dip_b (r_dip_b),
        .i_dip_c (r_dip_c),
        .o_res   (dec_res),
        .o_glue  (n_glue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_a <= DIP_RESET;
            r_dip_b <= DIP_RESET;
            r_dip_c <= DIP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIP_A: r_dip_a <= i_cfg_data;
                CFG_DIP_B: r_dip_b <= i_cfg_data;
                CFG_DIP_C: r_dip_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // commit glue state only when the transaction moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glue      <= '0;
            r_res_valid <= 1'b0;
        end else if (adv) begin
            r_res_valid <= in_valid;
            if (in_valid) begin
                r_glue <= n_glue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && in_valid) begin
            r_res <= dec_res;
        end
    end

    assign o_res.valid              = r_res_valid;
    assign o_res.target             = r_res.target;
    assign o_res.device_offset      = r_res.device_offset;
    assign o_res.read_data          = r_res.read_data;
    assign o_res.device_write_data  = r_res.device_write_data;
    assign o_res.sub_fast_irq       = r_res.sub_fast_irq;
    assign o_res.sound_irq          = r_res.sound_irq;
    assign o_res.watchdog_kick      = r_res.watchdog_kick;
    assign o_res.layer_priority     = r_res.layer_priority;
    assign o_res.tile_rom_read_mode = r_res.tile_rom_read_mode;
    assign o_res.zoom_wraparound    = r_res.zoom_wraparound;

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> $onehot0({r_res.sub_fast_irq, r_res.sound_irq, r_res.watchdog_kick}))
        else $error("more than one pulse on one transaction");

    a_rd_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.target != TGT_NONE) |-> (r_res.read_data == 8'h00))
        else $error("read data on a device transaction");

    a_wd_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.target == TGT_NONE) |-> (r_res.device_write_data == 8'h00))
        else $error("write data with no target");

    a_main_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_glue.main_rom_bank <= 4'd11)
        else $error("main ROM bank out of range");

    a_sub_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.target == TGT_SUB_ROM) |-> (r_res.device_offset[16:13] < SUB_BANKS))
        else $error("sub ROM window beyond last bank");

endmodule

// ===== bench/three_cpu_bus_decoder_test.sv =====
module three_cpu_bus_decoder_test;
    import tcbd_pkg::*;

    localparam int          QUIET_LIMIT  = 2000;
    localparam int          SETTLE_TICKS = 6;
    localparam logic [7:0]  GUN_STEP     = 8'd17;
    localparam logic [7:0]  VOL_SCALE    = 8'd8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    tcbd_acc_if acc_bus ();
    tcbd_res_if res_bus ();

    three_cpu_bus_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc_bus),
        .o_res      (res_bus)
    );

    // predictor copy of the glue registers and the DIP bytes
    t_glue      glue;
    logic [7:0] dip_a;
    logic [7:0] dip_b;
    logic [7:0] dip_c;

    t_result    pending_results[$];
    int         mismatch_count;
    int         results_seen;
    int         quiet_cycles;
    int         src_idle_pct;
    int         sink_stall_pct;
    int         hold_request;
    int         hold_left;
    logic       port_fill;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_result decode_access(input t_access a);
        t_result     r;
        t_group      grp;
        logic        wr;
        logic        vol_write;
        logic [15:0] adr;
        logic [7:0]  d;
        logic [3:0]  sub_bank;
        r = '0;
        wr = (a.operation == OP_WRITE);
        adr = a.address;
        d = a.write_data;
        vol_write = 1'b0;
        case (t_bus_port'(a.bus_port))
            PORT_MAIN: begin
                if (adr <= 16'h01c0) begin
                    grp = t_group'(adr[8:6]);
                    if (!wr) begin
                        r.read_data = 8'hff;
                        case (grp)
                            GRP_GUN: begin
                                r.read_data = glue.gun_counter * GUN_STEP + GUN_SEED;
                                glue.gun_counter = glue.gun_counter + 8'd1;
                            end
                            GRP_P2: r.read_data = a.player_two_port;
                            GRP_INPUTS: begin
                                case (adr[1:0])
                                    SEL_SYSTEM: r.read_data = a.system_port;
                                    SEL_P1:     r.read_data = a.player_one_port;
                                    SEL_DIP_A:  r.read_data = dip_a;
                                    default:    r.read_data = dip_b;
                                endcase
                            end
                            GRP_DIP_C: r.read_data = dip_c;
                            default: ;
                        endcase
                    end else begin
                        case (grp)
                            GRP_GUN: begin
                                if (adr == 16'h0000) r.sub_fast_irq = glue.sub_firq_enabled;
                                else r.watchdog_kick = 1'b1;
                            end
                            GRP_SIRQ: r.sound_irq = 1'b1;
                            GRP_LATCH: glue.sound_latch_byte = d;
                            GRP_BANK: begin
                                // bit 7 clear offsets the bank number by four
                                glue.main_rom_bank = (d[7] ? 4'd0 : 4'd4) + {1'b0, d[2:0]};
                                glue.priority_flag = d[3];
                            end
                            default: ;
                        endcase
                    end
                end else if (adr >= 16'h0800 && adr <= 16'h0807) begin
                    r.target = TGT_SPRITE_REGS;
                    r.device_offset = 17'(adr[2:0]);
                end else if (adr >= 16'h0c00 && adr <= 16'h0fff) begin
                    r.target = TGT_SPRITE_RAM;
                    r.device_offset = 17'(adr - 16'h0c00);
                end else if (adr >= 16'h1000 && adr <= 16'h1fff) begin
                    r.target = TGT_PALETTE;
                    r.device_offset = 17'(adr[11:0]);
                end else if (adr >= 16'h2000 && adr <= 16'h3fff) begin
                    r.target = TGT_SHARED_RAM;
                    r.device_offset = 17'(adr[12:0]);
                end else if (adr >= 16'h4000 && adr <= 16'h5fff) begin
                    r.target = TGT_MAIN_MEM;
                    r.device_offset = 17'(adr);
                end else if (!wr) begin
                    if (adr >= 16'h6000 && adr <= 16'h7fff) begin
                        r.target = TGT_MAIN_ROM;
                        r.device_offset = {glue.main_rom_bank, adr[12:0]};
                    end else begin
                        r.target = TGT_MAIN_MEM;
                        r.device_offset = 17'(adr);
                    end
                end
            end
            PORT_SUB: begin
                if (adr <= 16'h07ff) begin
                    r.target = TGT_ZOOM_RAM;
                    r.device_offset = 17'(adr);
                end else if (adr >= 16'h2000 && adr <= 16'h3fff) begin
                    r.target = TGT_SHARED_RAM;
                    r.device_offset = 17'(adr[12:0]);
                end else if (adr >= 16'h4000 && adr <= 16'h7fff) begin
                    r.target = TGT_TILE_CHIP;
                    r.device_offset = 17'(adr[13:0]);
                end else if (wr) begin
                    if (adr >= 16'h0800 && adr <= 16'h080f) begin
                        r.target = TGT_ZOOM_CTRL;
                        r.device_offset = 17'(adr[3:0]);
                    end else if (adr == 16'h1800) begin
                        glue.rom_read_flag = d[6];
                        glue.wraparound_flag = d[5];
                        glue.sub_firq_enabled = d[4];
                        glue.sub_rom_bank = d[3:0];
                    end
                end else if (adr >= 16'h1000 && adr <= 16'h17ff) begin
                    r.target = TGT_ZOOM_ROM;
                    r.device_offset = 17'(adr[10:0]);
                end else if (adr >= 16'h8000 && adr <= 16'h9fff) begin
                    // banks past the last one fold back
                    sub_bank = glue.sub_rom_bank % SUB_BANKS;
                    r.target = TGT_SUB_ROM;
                    r.device_offset = {sub_bank, adr[12:0]};
                end else begin
                    r.target = TGT_SUB_MEM;
                    r.device_offset = 17'(adr);
                end
            end
            PORT_SOUND: begin
                if (adr >= 16'ha000 && adr <= 16'ha00d) begin
                    r.target = TGT_PCM0;
                    r.device_offset = 17'(adr[3:0]);
                end else if (adr >= 16'hb000 && adr <= 16'hb00d) begin
                    r.target = TGT_PCM1;
                    r.device_offset = 17'(adr[3:0]);
                end else if (!wr) begin
                    if (adr <= 16'h87ff) begin
                        r.target = TGT_SOUND_MEM;
                        r.device_offset = 17'(adr);
                    end else if (adr == 16'hc001) begin
                        r.target = TGT_FM_STATUS;
                    end else if (adr == 16'he000) begin
                        r.read_data = glue.sound_latch_byte;
                    end
                end else if (adr >= 16'h8000 && adr <= 16'h87ff) begin
                    r.target = TGT_SOUND_MEM;
                    r.device_offset = 17'(adr);
                end else if (adr == 16'h9000) begin
                    r.target = TGT_PCM_BANK;
                end else if (adr == 16'hb80c) begin
                    r.target = TGT_PCM1_VOL;
                    r.device_write_data = d[3:0] * VOL_SCALE;
                    vol_write = 1'b1;
                end else if (adr == 16'hc000) begin
                    r.target = TGT_FM_SELECT;
                end else if (adr == 16'hc001) begin
                    r.target = TGT_FM_DATA;
                end
            end
            default: ;
        endcase
        if (!wr || r.target == TGT_NONE) r.device_write_data = '0;
        else if (!vol_write) r.device_write_data = d;
        if (wr || r.target != TGT_NONE) r.read_data = '0;
        r.layer_priority = glue.priority_flag;
        r.tile_rom_read_mode = glue.rom_read_flag;
        r.zoom_wraparound = glue.wraparound_flag;
        return r;
    endfunction

    function automatic logic [15:0] window_address(input t_bus_port port);
        case (port)
            PORT_MAIN: begin
                case ($urandom_range(9))
                    0, 1, 2: return 16'($urandom_range(16'h01c0));
                    3:       return 16'(($urandom_range(7) << 6) | $urandom_range(3));
                    4:       return 16'($urandom_range(16'h0807, 16'h0800));
                    5:       return 16'($urandom_range(16'h0fff, 16'h01c1));
                    6:       return 16'($urandom_range(16'h5fff, 16'h1000));
                    7, 8:    return 16'($urandom_range(16'h7fff, 16'h6000));
                    default: return 16'($urandom_range(16'hffff, 16'h8000));
                endcase
            end
            PORT_SUB: begin
                case ($urandom_range(9))
                    0:       return 16'($urandom_range(16'h07ff));
                    1:       return 16'($urandom_range(16'h0810, 16'h0800));
                    2, 3:    return 16'h1800;
                    4:       return 16'($urandom_range(16'h1fff, 16'h0811));
                    5:       return 16'($urandom_range(16'h7fff, 16'h2000));
                    6, 7:    return 16'($urandom_range(16'h9fff, 16'h8000));
                    default: return 16'($urandom_range(16'hffff, 16'ha000));
                endcase
            end
            PORT_SOUND: begin
                case ($urandom_range(9))
                    0:       return 16'($urandom_range(16'h87ff));
                    1:       return 16'($urandom_range(16'ha00f, 16'ha000));
                    2:       return 16'($urandom_range(16'hb00f, 16'hb000));
                    3:       return 16'hb80c;
                    4:       return 16'($urandom_range(16'hc001, 16'hc000));
                    5:       return 16'he000;
                    6:       return 16'h9000;
                    7:       return 16'($urandom_range(16'hffff, 16'h8800));
                    default: return 16'($urandom_range(16'hffff));
                endcase
            end
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    function automatic t_access random_access();
        t_access   a;
        t_bus_port port;
        if ($urandom_range(99) < 4) port = PORT_NONE;
        else port = t_bus_port'($urandom_range(2));
        a.bus_port = port;
        a.operation = $urandom_range(1) ? OP_WRITE : OP_READ;
        if ($urandom_range(99) < 15) a.address = 16'($urandom_range(16'hffff));
        else a.address = window_address(port);
        a.write_data = 8'($urandom_range(8'hff));
        a.player_one_port = 8'($urandom_range(8'hff));
        a.player_two_port = 8'($urandom_range(8'hff));
        a.system_port = 8'($urandom_range(8'hff));
        return a;
    endfunction

    task automatic send_access(input t_access a);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            acc_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        acc_bus.valid = 1'b1;
        acc_bus.bus_port = a.bus_port;
        acc_bus.operation = a.operation;
        acc_bus.address = a.address;
        acc_bus.write_data = a.write_data;
        acc_bus.player_one_port = a.player_one_port;
        acc_bus.player_two_port = a.player_two_port;
        acc_bus.system_port = a.system_port;
        @(posedge i_clk);
        while (!acc_bus.ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), decode_access(a));
    endtask

    // fixed transaction; live port bytes alternate between all-zero and all-one
    task automatic send_fixed(input t_bus_port port, input logic op,
                              input logic [15:0] adr, input logic [7:0] d);
        t_access a;
        a.bus_port = port;
        a.operation = op;
        a.address = adr;
        a.write_data = d;
        a.player_one_port = {8{port_fill}};
        a.player_two_port = {8{port_fill}};
        a.system_port = {8{port_fill}};
        port_fill = ~port_fill;
        send_access(a);
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        @(negedge i_clk);
        acc_bus.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic write_dip(input logic [1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_DIP_A: dip_a = value;
            CFG_DIP_B: dip_b = value;
            CFG_DIP_C: dip_c = value;
            default: ;
        endcase
    endtask

    task automatic set_dips(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        settle();
        write_dip(CFG_DIP_A, a);
        write_dip(CFG_DIP_B, b);
        write_dip(CFG_DIP_C, c);
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // receiver: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            res_bus.ready = 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request - 1;
            hold_request = 0;
            res_bus.ready = 1'b0;
        end else begin
            res_bus.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch("result with no transaction outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("target", 32'(res_bus.target), 32'(want.target));
                check_field("device_offset", 32'(res_bus.device_offset),
                            32'(want.device_offset));
                check_field("read_data", 32'(res_bus.read_data), 32'(want.read_data));
                check_field("device_write_data", 32'(res_bus.device_write_data),
                            32'(want.device_write_data));
                check_field("sub_fast_irq", 32'(res_bus.sub_fast_irq),
                            32'(want.sub_fast_irq));
                check_field("sound_irq", 32'(res_bus.sound_irq), 32'(want.sound_irq));
                check_field("watchdog_kick", 32'(res_bus.watchdog_kick),
                            32'(want.watchdog_kick));
                check_field("layer_priority", 32'(res_bus.layer_priority),
                            32'(want.layer_priority));
                check_field("tile_rom_read_mode", 32'(res_bus.tile_rom_read_mode),
                            32'(want.tile_rom_read_mode));
                check_field("zoom_wraparound", 32'(res_bus.zoom_wraparound),
                            32'(want.zoom_wraparound));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (acc_bus.valid && acc_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_fixed(PORT_MAIN,  OP_READ,  16'h0000, 8'h00);
        send_fixed(PORT_MAIN,  OP_READ,  16'h003f, 8'hff);
        send_fixed(PORT_MAIN,  OP_WRITE, 16'h0000, 8'hff);
        send_fixed(PORT_SUB,   OP_WRITE, 16'h1800, 8'h7f);
        send_fixed(PORT_MAIN,  OP_WRITE, 16'h0000, 8'h00);
        send_fixed(PORT_MAIN,  OP_WRITE, 16'h003f, 8'h55);
        send_fixed(PORT_MAIN,  OP_WRITE, 16'h0040, 8'haa);
        send_fixed(PORT_MAIN,  OP_WRITE, 16'h0080, 8'ha5);
        send_fixed(PORT_SOUND, OP_READ,  16'he000, 8'h00);
        send_fixed(PORT_MAIN,  OP_WRITE, 16'h00c0, 8'h0f);
        send_fixed(PORT_MAIN,  OP_READ,  16'h7fff, 8'h00);
        send_fixed(PORT_SUB,   OP_READ,  16'h9fff, 8'h00);
        send_fixed(PORT_MAIN,  OP_WRITE, 16'h00ff, 8'h80);
        send_fixed(PORT_MAIN,  OP_READ,  16'h0100, 8'h00);
        send_fixed(PORT_MAIN,  OP_READ,  16'h0180, 8'h00);
        send_fixed(PORT_MAIN,  OP_READ,  16'h0181, 8'h00);
        send_fixed(PORT_MAIN,  OP_READ,  16'h0182, 8'h00);
        send_fixed(PORT_MAIN,  OP_READ,  16'h0183, 8'h00);
        send_fixed(PORT_MAIN,  OP_READ,  16'h01c0, 8'h00);
        send_fixed(PORT_MAIN,  OP_READ,  16'h0140, 8'h00);
        send_fixed(PORT_SOUND, OP_WRITE, 16'hb80c, 8'hff);
        send_fixed(PORT_NONE,  OP_WRITE, 16'hffff, 8'hff);
        send_fixed(PORT_MAIN,  OP_WRITE, 16'hffff, 8'h00);
        send_fixed(PORT_SUB,   OP_WRITE, 16'h1800, 8'h00);
        send_fixed(PORT_SOUND, OP_READ,  16'hc001, 8'h00);
    endtask

    task automatic test_traffic(input int count, input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count) send_access(random_access());
    endtask

    // stall the result side long enough that the input side backs up
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = 80;
        repeat (40) send_access(random_access());
    endtask

    task automatic test_drain_pause();
        src_idle_pct = 19;
        sink_stall_pct = 19;
        repeat (20) send_access(random_access());
        settle();
        repeat (20) send_access(random_access());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DIP_A;
        i_cfg_data = '0;
        acc_bus.valid = 1'b0;
        acc_bus.bus_port = PORT_MAIN;
        acc_bus.operation = OP_READ;
        acc_bus.address = '0;
        acc_bus.write_data = '0;
        acc_bus.player_one_port = '0;
        acc_bus.player_two_port = '0;
        acc_bus.system_port = '0;
        res_bus.ready = 1'b0;
        glue = '0;
        dip_a = DIP_RESET;
        dip_b = DIP_RESET;
        dip_c = DIP_RESET;
        mismatch_count = 0;
        results_seen = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        port_fill = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        set_dips(8'h00, 8'h00, 8'h00);
        test_traffic(400, 0, 0);
        set_dips(8'hff, 8'hff, 8'hff);
        test_traffic(400, 49, 0);
        set_dips(8'($urandom_range(8'hff)), 8'($urandom_range(8'hff)),
                 8'($urandom_range(8'hff)));
        test_traffic(400, 0, 49);
        set_dips(8'ha5, 8'h5a, 8'h81);
        test_traffic(400, 19, 19);
        test_backpressure();
        test_drain_pause();

        @(negedge i_clk);
        acc_bus.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
